>>> rtl/periodic_timer_bank_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic timer bank
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PTB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Transfer types, request codes and slot record shared by the bank's modules.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int PERIOD_W   = 16;
   localparam int LIMIT_W    = 8;
   localparam int MS_W       = 32;
   localparam int SUB_W      = 10;
   localparam int MASK_W     = 2;

   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_REGISTER = 2'd1;
   localparam logic [1:0] REQ_POLL     = 2'd2;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [PERIOD_W-1:0] period_ticks;
      logic [LIMIT_W-1:0]  repeat_limit;
   } req_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] fired_mask;
      logic [MS_W-1:0]   ms_count;
      logic              second_flag;
      logic              accepted;
   } rsp_item_type;

   // One timer slot as seen by the shared update unit.
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [LIMIT_W-1:0]  limit;
      logic [PERIOD_W-1:0] elapsed;
      logic [LIMIT_W-1:0]  fired_count;
      logic                active;
   } slot_rec_type;

endpackage

>>> rtl/ptb_slot_step.sv
// ----------------------------------------------------------------------------
// Timer slot update unit
// Advances an active slot by one tick: fire and restart (retiring the slot once
// its repeat limit is reached), or count up. An inactive slot is left as it is.
module ptb_slot_step
   import ptb_pkg::*;
(
   input  slot_rec_type slot_cur,
   output slot_rec_type slot_next,
   output logic         fire
);

   logic [LIMIT_W-1:0] fired_inc;

   assign fired_inc = slot_cur.fired_count + LIMIT_W'(1);

   always_comb begin
      slot_next = slot_cur;
      fire      = 1'b0;
      if (slot_cur.active) begin
         if (slot_cur.elapsed >= slot_cur.period) begin
            slot_next.elapsed = '0;
            fire              = 1'b1;
            if (slot_cur.limit != '0) begin
               slot_next.fired_count = fired_inc;
               if (fired_inc >= slot_cur.limit) begin
                  slot_next.active = 1'b0;
               end
            end
         end else begin
            slot_next.elapsed = slot_cur.elapsed + PERIOD_W'(1);
         end
      end
   end

endmodule

>>> rtl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// Periodic timer bank
// Millisecond-tick driven bank of repeating timer slots with a seconds flag.
// ----------------------------------------------------------------------------
// A tick request passes each slot registered so far (at most NUM_SLOTS)
// through the shared update unit, one slot record per cycle, and then
// loads its result into the output register in the finish step; with no
// slot registered it goes straight to the finish step. Register and poll
// requests, and the unused request code, go straight to the finish step.
// The input side takes no new transfer until the current result has been
// loaded. The load step waits while an earlier result still sits in the
// output register under rsp_stall. A loaded result may then wait on
// rsp_stall while the next request is already being worked on.
// ----------------------------------------------------------------------------
module periodic_timer_bank
   import ptb_pkg::*;
#(
   parameter int NUM_SLOTS        = 2,
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

`include "periodic_timer_bank_macros.svh"

   // Slot index width and the width of a count that can reach NUM_SLOTS.
   localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNTW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [IDXW-1:0]     idx_ff, idx_in;
   logic [CNTW-1:0]     slots_used_ff, slots_used_in;
   logic [MS_W-1:0]     ms_counter_ff, ms_counter_in;
   logic [SUB_W-1:0]    sub_count_ff, sub_count_in;
   logic                pending_ff, pending_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                flag_ff, flag_in;
   logic                acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   // Slot storage. Only the active bits need a reset; the rest is written
   // when a slot is registered and is read only for registered slots.
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [PERIOD_W-1:0]  period_ff  [NUM_SLOTS];
   logic [LIMIT_W-1:0]   limit_ff   [NUM_SLOTS];
   logic [PERIOD_W-1:0]  elapsed_ff [NUM_SLOTS];
   logic [LIMIT_W-1:0]   fcount_ff  [NUM_SLOTS];

   logic                 wr_en;
   logic [IDXW-1:0]      wr_idx;
   slot_rec_type         wr_rec;

   slot_rec_type         walk_cur, walk_next;
   logic                 walk_fire;
   logic                 req_xfer;
   logic                 walk_last;
   logic [SUB_W-1:0]     sub_inc;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The slot under the walk index goes through the shared update unit.
   assign walk_cur.period      = period_ff[idx_ff];
   assign walk_cur.limit       = limit_ff[idx_ff];
   assign walk_cur.elapsed     = elapsed_ff[idx_ff];
   assign walk_cur.fired_count = fcount_ff[idx_ff];
   assign walk_cur.active      = active_ff[idx_ff];

   ptb_slot_step u_slot_step (
      .slot_cur  (walk_cur),
      .slot_next (walk_next),
      .fire      (walk_fire)
   );

   assign walk_last = ((CNTW'(idx_ff) + CNTW'(1)) == slots_used_ff);
   assign sub_inc   = sub_count_ff + SUB_W'(1);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      slots_used_in = slots_used_ff;
      ms_counter_in = ms_counter_ff;
      sub_count_in  = sub_count_ff;
      pending_in    = pending_ff;
      mask_in       = mask_ff;
      flag_in       = flag_ff;
      acc_in        = acc_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_rec        = walk_next;

      // A delivered result frees the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mask_in  = '0;
               flag_in  = 1'b0;
               acc_in   = 1'b0;
               idx_in   = '0;
               state_in = ST_FINISH;
               unique case (req_data.req_type)
                  REQ_TICK: begin
                     ms_counter_in = ms_counter_ff + MS_W'(1);
                     if (sub_inc == SUB_W'(TICKS_PER_SECOND)) begin
                        sub_count_in = '0;
                        pending_in   = 1'b1;
                     end else begin
                        sub_count_in = sub_inc;
                     end
                     if (slots_used_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  REQ_REGISTER: begin
                     if (slots_used_ff < CNTW'(NUM_SLOTS)) begin
                        wr_en                     = 1'b1;
                        wr_idx                    = slots_used_ff[IDXW-1:0];
                        wr_rec.period             = req_data.period_ticks;
                        wr_rec.limit              = req_data.repeat_limit;
                        wr_rec.elapsed            = '0;
                        wr_rec.fired_count        = '0;
                        wr_rec.active             = 1'b1;
                        active_in[wr_idx]         = 1'b1;
                        slots_used_in             = slots_used_ff + CNTW'(1);
                        acc_in                    = 1'b1;
                     end
                  end
                  REQ_POLL: begin
                     flag_in    = pending_ff;
                     pending_in = 1'b0;
                  end
                  default: begin
                     // The unused request code changes nothing.
                  end
               endcase
            end
         end
         ST_WALK: begin
            wr_en             = 1'b1;
            active_in[idx_ff] = walk_next.active;
            // Only the first two slots have a bit in the fired mask.
            if (walk_fire && ((idx_ff >> 1) == '0)) begin
               mask_in[idx_ff[0]] = 1'b1;
            end
            if (walk_last) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + IDXW'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.fired_mask  = mask_ff;
               rsp_data_in.ms_count    = ms_counter_ff;
               rsp_data_in.second_flag = flag_ff;
               rsp_data_in.accepted    = acc_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         slots_used_ff <= '0;
         ms_counter_ff <= '0;
         sub_count_ff  <= '0;
         pending_ff    <= 1'b0;
         active_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         slots_used_ff <= slots_used_in;
         ms_counter_ff <= ms_counter_in;
         sub_count_ff  <= sub_count_in;
         pending_ff    <= pending_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      flag_ff     <= flag_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (wr_en) begin
         period_ff[wr_idx]  <= wr_rec.period;
         limit_ff[wr_idx]   <= wr_rec.limit;
         elapsed_ff[wr_idx] <= wr_rec.elapsed;
         fcount_ff[wr_idx]  <= wr_rec.fired_count;
      end
   end

   // The fill count never passes the number of slots.
   `PTB_ASSERT(a_slots_in_range, clock, reset, slots_used_ff <= CNTW'(NUM_SLOTS), "slot count overflow")

   // A register transfer into a bank with room takes exactly one more slot.
   `PTB_ASSERT_NEXT(a_register_fills, clock, reset, req_xfer && (req_data.req_type == REQ_REGISTER) && (slots_used_ff < CNTW'(NUM_SLOTS)), slots_used_ff == $past(slots_used_ff) + CNTW'(1), "register did not fill a slot")

   // The millisecond count moves only on a tick transfer.
   `PTB_ASSERT_NEXT(a_ms_only_on_tick, clock, reset, !(req_xfer && (req_data.req_type == REQ_TICK)), $stable(ms_counter_ff), "millisecond count moved without a tick")

   // Slots beyond the fill count are never active.
   `PTB_ASSERT(a_active_within_used, clock, reset, (active_ff >> slots_used_ff) == '0, "active slot beyond fill count")

endmodule
